// ===== design/upd_pkg.sv =====
// shared types, constants and hex helpers for the uri percent decoder
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_PCT   = 2'd1,
        PHASE_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_end;
        logic       text_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                         count;
        logic [MAX_RESULTS-1:0][7:0]        bytes;
        phase_t                             next_phase;
        logic [7:0]                         next_held;
    } dec_result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// ===== design/upd_decode.sv =====
// escape decode for one item: result bytes, count and next escape state
module upd_decode (
    input  upd_pkg::phase_t      phase,
    input  logic [7:0]           held,
    input  upd_pkg::in_item_t    item,
    output upd_pkg::dec_result_t res
);
    import upd_pkg::*;

    logic [7:0] b;
    logic       fin;
    logic       b_hex;
    logic [1:0] pre_cnt;
    logic [7:0] pre0;
    logic [7:0] pre1;
    logic       do_fresh;
    logic       fresh_emit;

    assign b     = item.char_in;
    assign fin   = item.is_final;
    assign b_hex = is_hex(b);

    always_comb begin
        res            = '0;
        res.next_phase = PHASE_IDLE;
        res.next_held  = held;
        pre_cnt        = 2'd0;
        pre0           = PCT_CHAR;
        pre1           = held;
        do_fresh       = 1'b1;
        fresh_emit     = 1'b0;

        unique case (phase)
            PHASE_PCT: begin
                if (b_hex && !fin) begin
                    do_fresh       = 1'b0;
                    res.next_phase = PHASE_DIGIT;
                    res.next_held  = b;
                end else begin
                    pre_cnt = 2'd1;
                end
            end
            PHASE_DIGIT: begin
                if (b_hex && is_hex(held)) begin
                    do_fresh = 1'b0;
                    pre_cnt  = 2'd1;
                    pre0     = {hex_val(held), hex_val(b)};
                end else begin
                    pre_cnt = 2'd2;
                end
            end
            default: begin
                pre_cnt = 2'd0;
            end
        endcase

        if (do_fresh) begin
            if ((b == PCT_CHAR) && !fin) begin
                res.next_phase = PHASE_PCT;
            end else begin
                fresh_emit = 1'b1;
            end
        end

        res.bytes[0] = pre0;
        res.bytes[1] = pre1;
        res.bytes[2] = b;
        if (pre_cnt == 2'd0) begin
            res.bytes[0] = b;
        end else if (pre_cnt == 2'd1) begin
            res.bytes[1] = b;
        end
        res.count = pre_cnt + {1'b0, fresh_emit};

        if (fin) begin
            res.next_phase = PHASE_IDLE;
        end
    end

endmodule

// ===== design/uri_percent_decoder_core.sv =====
// top level of the streaming uri percent decoder
//
// input channel s_valid/s_ready/s_item carries one raw byte per item with a
// flag on the byte that ends the text; output channel m_valid/m_ready/m_item
// carries decoded bytes, run_end on the last result of each input item and
// text_end on the last result of the text.
// an accepted item sits in an input register; the decode logic works on it
// and its results are loaded one per cycle into the output register while the output is not stalled.
// the first result of an item goes straight from the input register into
// the output register, with no other register between them.
// an item that gives zero or one result frees the input register once its
// result, if any, is loaded, so such items stream at one per cycle unless the
// output stalls; an item with more results (at most three) holds it until its
// last result is loaded into the single output register, one result per cycle.
// reset (aresetn low at a clock edge) drops any pending item and result and
// clears the escape state.
// when the receiver stalls the output register holds its result, the input
// register fills and s_ready falls until results drain.
module uri_percent_decoder_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  upd_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output upd_pkg::out_item_t m_item
);
    import upd_pkg::*;

    logic        stage_valid_reg;
    in_item_t    stage_item_reg;
    logic [1:0]  idx_reg;
    phase_t      phase_reg;
    logic [7:0]  held_reg;
    logic        m_valid_reg;
    out_item_t   m_item_reg;

    dec_result_t dec;
    logic        out_load;
    logic        last_load;
    logic        stage_done;
    out_item_t   m_item_next;

    upd_decode u_decode (
        .phase (phase_reg),
        .held  (held_reg),
        .item  (stage_item_reg),
        .res   (dec)
    );

    assign out_load   = stage_valid_reg && (dec.count != 2'd0) && (!m_valid_reg || m_ready);
    assign last_load  = (idx_reg == (dec.count - 2'd1));
    assign stage_done = stage_valid_reg && ((dec.count == 2'd0) || (out_load && last_load));
    assign s_ready    = !stage_valid_reg || stage_done;

    always_comb begin
        m_item_next.char_out = dec.bytes[idx_reg];
        m_item_next.run_end  = last_load;
        m_item_next.text_end = last_load && stage_item_reg.is_final;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            idx_reg         <= 2'd0;
            phase_reg       <= PHASE_IDLE;
            held_reg        <= 8'h00;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                stage_valid_reg <= 1'b1;
            end else if (stage_done) begin
                stage_valid_reg <= 1'b0;
            end
            if (stage_done) begin
                phase_reg <= dec.next_phase;
                held_reg  <= dec.next_held;
                idx_reg   <= 2'd0;
            end else if (out_load) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_item_reg <= s_item;
        end
        if (out_load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== design/upd_checker.sv =====
// port-level checks for the uri percent decoder, bound to the top level
module upd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input upd_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input upd_pkg::out_item_t m_item
);
    import upd_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_item)))
        else $error("waiting input item changed");

    a_text_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_item.text_end || m_item.run_end))
        else $error("text end without run end");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_item.run_end) |=> m_valid)
        else $error("gap inside a run of results");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("stalled result changed");

endmodule

bind uri_percent_decoder_core upd_checker u_upd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
